// File: rtl/tmcp_pkg.sv
// Shared types and constants for the tile map collision probe.
// No dependencies.
`default_nettype none
package tmcp_pkg;
    localparam int MaxColumns = 64;
    localparam int MaxRows    = 64;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLID = 2'd1;
    localparam logic [1:0] OP_ALT   = 2'd2;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_TILE     = 3'd2;
    localparam logic [2:0] CFG_COLS     = 3'd3;
    localparam logic [2:0] CFG_ROWS     = 3'd4;

    // Signed work width for doubled-resolution geometry.
    localparam int GeoW = 44;

    typedef struct packed {
        logic               start;
        logic [GeoW-1:0]    num;
        logic [GeoW-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [GeoW-1:0]    quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// File: rtl/tmcp_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tmcp_pkg.
`default_nettype none
module tmcp_divider
    import tmcp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int CntW = $clog2(GeoW + 1);

    logic [GeoW-1:0] r_rem, n_rem;
    logic [GeoW-1:0] r_quo, n_quo;
    logic [GeoW-1:0] r_den;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [GeoW:0]   w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[GeoW-1]} - {1'b0, r_den};
        if (w_trial[GeoW]) begin
            n_rem = {r_rem[GeoW-2:0], r_quo[GeoW-1]};
            n_quo = {r_quo[GeoW-2:0], 1'b0};
        end else begin
            n_rem = w_trial[GeoW-1:0];
            n_quo = {r_quo[GeoW-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(GeoW);
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

// File: rtl/tile_map_collision_probe_top.sv
// Top level of the tile map collision probe: sequencer, tile memory, divider.
// Depends on tmcp_pkg and tmcp_divider.
`default_nettype none
// Channel  | valid      | stall      | payload
// in       | i_in_valid | o_in_stall | opcode, tile_address, tile_value, probe_x/y
// out      | o_out_valid| i_out_stall| is_solid, overlap_x/y, altitude
// cfg      | i_cfg_we   | (none)     | i_cfg_index, i_cfg_data
// A write or an unused opcode goes from accept straight to the output state. A probe
// inside the map runs two 44-bit serial divisions (column, row), then a read.
// An altitude query over the map's columns runs the same two divisions, then scans
// rows through the one read port: row address, read, read wait, then test.
// After reset a clearing pass writes all MAX_COLUMNS*MAX_ROWS entries, one per cycle,
// with input stalled. Input stalls while an item is in flight; a finished word waits
// for the output register, which holds while output is stalled.
module tile_map_collision_probe_top
    import tmcp_pkg::*;
#(
    parameter int MAX_COLUMNS = MaxColumns,
    parameter int MAX_ROWS    = MaxRows
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [11:0]        i_tile_address,
    input  wire logic [7:0]         i_tile_value,
    input  wire logic signed [23:0] i_probe_x,
    input  wire logic signed [23:0] i_probe_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_is_solid,
    output logic [15:0]             o_overlap_x,
    output logic [15:0]             o_overlap_y,
    output logic signed [25:0]      o_altitude
);
    localparam int Depth = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_DIVX  = 4'd3;
    localparam logic [3:0] S_DIVY  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_MULR  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_OVL   = 4'd11;

    // Configuration.
    logic signed [23:0] r_org_x, r_org_y;
    logic [15:0]        r_tile;
    logic [6:0]         r_cols_cfg, r_rows_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_tile     <= 16'd4096;
            r_cols_cfg <= 7'd64;
            r_rows_cfg <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_org_x    <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y    <= i_cfg_data;
                CFG_TILE:     r_tile     <= i_cfg_data[15:0];
                CFG_COLS:     r_cols_cfg <= i_cfg_data[6:0];
                CFG_ROWS:     r_rows_cfg <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Saturate counts to the store geometry.
    logic [CW-1:0] w_cols;
    logic [RW-1:0] w_rows;
    always_comb begin
        w_cols = ({25'd0, r_cols_cfg} > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(r_cols_cfg);
        w_rows = ({25'd0, r_rows_cfg} > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(r_rows_cfg);
    end

    // Sequencer state and item registers.
    logic [3:0]             r_state;
    logic [1:0]             r_op;
    logic signed [GeoW-1:0] r_py2, r_offx, r_offy, r_spanx, r_spany, r_top2, r_bot2;
    logic signed [GeoW-1:0] r_ts2;
    logic [GeoW-1:0]        r_colq, r_rowq;
    logic [RW-1:0]          r_row;
    logic [AW:0]            r_addr;
    logic signed [GeoW-1:0] r_prod;
    logic                   r_step;
    logic [AW-1:0]          r_clr;

    logic                   r_ov, r_solid;
    logic [15:0]            r_ovx, r_ovy;
    logic signed [25:0]     r_alt;
    logic signed [GeoW-1:0] r_alt2;

    // Tile memory, one write port and one read port.
    logic [7:0] mem [Depth];
    logic [7:0] r_rdata;
    logic       w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0] w_wdata;
    logic [AW-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    // Divider.
    t_div_req w_req;
    t_div_rsp w_rsp;
    tmcp_divider u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    logic w_in_acc;
    logic w_out_load;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    // Load the output register once it is empty or draining this cycle.
    assign w_out_load = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    // Geometry at twice the resolution; multiplies are narrow (8x17 bits, signed).
    logic signed [GeoW-1:0] w_cts, w_rts, w_left2, w_top2;
    always_comb begin
        w_cts  = GeoW'(signed'({1'b0, w_cols})) * GeoW'(signed'({1'b0, r_tile}));
        w_rts  = GeoW'(signed'({1'b0, w_rows})) * GeoW'(signed'({1'b0, r_tile}));
        w_left2 = GeoW'(r_org_x) * 2 - w_cts;
        w_top2  = GeoW'(r_org_y) * 2 - w_rts;
    end

    logic w_inx, w_iny;
    assign w_inx = (r_tile != 0) && (r_offx >= 0) && (r_offx < r_spanx);
    assign w_iny = (r_offy >= 0) && (r_offy < r_spany);

    // Overlap: dx = off - q*ts2 - ts.
    logic signed [GeoW-1:0] w_dx, w_dy, w_ox, w_oy;
    logic [15:0] w_hx, w_hy;
    always_comb begin
        w_dx = r_offx - r_prod - GeoW'(signed'({1'b0, r_tile}));
        w_dy = r_offy - r_alt2 - GeoW'(signed'({1'b0, r_tile}));
        if (w_dx < 0) w_dx = -w_dx;
        if (w_dy < 0) w_dy = -w_dy;
        w_ox = GeoW'(signed'({1'b0, r_tile})) - w_dx;
        w_oy = GeoW'(signed'({1'b0, r_tile})) - w_dy;
        w_hx = (w_ox < 0) ? 16'd0 : w_ox[16:1];
        w_hy = (w_oy < 0) ? 16'd0 : w_oy[16:1];
    end

    logic signed [GeoW-1:0] w_ah;
    logic signed [25:0]     w_asat;
    always_comb begin
        w_ah = r_alt2 >>> 1;
        if (w_ah > GeoW'(33554431))       w_asat = 26'sd33554431;
        else if (w_ah < -GeoW'(33554432)) w_asat = -26'sd33554432;
        else                              w_asat = w_ah[25:0];
    end

    logic [AW:0] w_rowbase;
    assign w_rowbase = (AW+1)'(r_row) * (AW+1)'(w_cols);

    always_comb begin
        w_req     = '0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_raddr   = r_addr[AW-1:0];
        if (r_state == S_CLEAR) begin
            w_we = 1'b1; w_waddr = r_clr;
        end else if (w_in_acc && i_opcode == OP_WRITE && {20'd0, i_tile_address} < Depth) begin
            w_we = 1'b1; w_waddr = AW'(i_tile_address); w_wdata = i_tile_value;
        end
        if (r_state == S_SETUP) begin
            w_req.start = 1'b1; w_req.num = r_offx; w_req.den = r_ts2;
        end else if (r_state == S_DIVX && w_rsp.done) begin
            w_req.start = 1'b1; w_req.num = (r_offy < 0) ? '0 : r_offy; w_req.den = r_ts2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_out_load) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(Depth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (w_in_acc) begin
                    r_op    <= i_opcode;
                    r_py2   <= GeoW'(i_probe_y) * 2;
                    r_offx  <= GeoW'(i_probe_x) * 2 - w_left2;
                    r_offy  <= GeoW'(i_probe_y) * 2 - w_top2;
                    r_spanx <= w_cts * 2;
                    r_spany <= w_rts * 2;
                    r_top2  <= w_top2;
                    r_bot2  <= GeoW'(r_org_y) * 2 + w_rts;
                    r_ts2   <= GeoW'({r_tile, 1'b0});
                    r_solid <= 1'b0; r_ovx <= '0; r_ovy <= '0; r_alt <= '0;
                    if (i_opcode == OP_SOLID || i_opcode == OP_ALT) r_state <= S_SETUP;
                    else r_state <= S_OUT;
                end
                S_SETUP: begin
                    r_alt2 <= r_bot2 - r_py2;
                    if (!w_inx || (r_op == OP_SOLID && !w_iny)) r_state <= S_FIN;
                    else r_state <= S_DIVX;
                end
                S_DIVX: if (w_rsp.done) begin
                    r_colq  <= w_rsp.quo;
                    r_state <= S_DIVY;
                end
                S_DIVY: if (w_rsp.done) begin
                    r_rowq <= w_rsp.quo;
                    // A start row below the map ends the scan at its first test.
                    r_row  <= (w_rsp.quo >= GeoW'(w_rows)) ? w_rows : RW'(w_rsp.quo);
                    r_step <= 1'b0;
                    r_state <= S_MULR;
                end
                S_MULR: begin
                    // Row address, then read.
                    r_addr  <= w_rowbase + (AW+1)'(r_colq);
                    r_state <= S_RD;
                end
                S_RD: r_state <= (r_op == OP_SOLID) ? S_CHK : S_SCAN;
                S_CHK: begin
                    if (r_rdata != 0) begin
                        r_solid <= 1'b1;
                        r_prod  <= GeoW'(r_colq[CW-1:0]) * GeoW'(r_ts2[16:0]);
                        r_alt2  <= GeoW'(r_rowq[RW-1:0]) * GeoW'(r_ts2[16:0]);
                        r_state <= S_OVL;
                    end else r_state <= S_OUT;
                end
                S_OVL: begin
                    r_ovx <= w_hx; r_ovy <= w_hy;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    // Scan loop: read wait, then test and advance a row.
                    if ({1'b0, r_row} >= {1'b0, w_rows}) r_state <= S_FIN;
                    else if (!r_step) r_step <= 1'b1;
                    else if (r_rdata != 0) begin
                        r_alt2  <= r_top2 + GeoW'(r_row) * GeoW'(r_ts2[16:0]) - r_py2;
                        r_state <= S_FIN;
                    end else begin
                        r_step <= 1'b0;
                        r_row  <= r_row + 1'b1;
                        r_state <= S_MULR;
                    end
                end
                S_FIN: begin
                    if (r_op == OP_ALT) r_alt <= w_asat;
                    r_state <= S_OUT;
                end
                S_OUT: if (w_out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_is_solid  <= r_solid;
            o_overlap_x <= r_ovx;
            o_overlap_y <= r_ovy;
            o_altitude  <= r_alt;
        end
    end
    assign o_out_valid = r_ov;

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("input taken while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_altitude)) else $error("result changed");
    a_solid_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_solid && r_state == S_OUT) |-> (r_op == OP_SOLID)) else $error("solid on non-probe");
endmodule
`default_nettype wire
